[src/doubly_linked_list_engine_top_defines.svh]
// Assertion macros shared by the list engine modules.
`ifndef DOUBLY_LINKED_LIST_ENGINE_TOP_DEFINES_SVH
`define DOUBLY_LINKED_LIST_ENGINE_TOP_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define DLL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication checked in the cycle after the antecedent.
`define DLL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[src/dll_pkg.sv]
// Package with the types, codes and defaults of the list engine.
package dll_pkg;
  localparam int DEF_NODES = 256;
  localparam int DEF_VALUE_BITS = 32;

  localparam logic [3:0] FN_INS_FIRST = 4'd0;
  localparam logic [3:0] FN_INS_AFTER = 4'd1;
  localparam logic [3:0] FN_INS_BEFORE = 4'd2;
  localparam logic [3:0] FN_INS_SORTED = 4'd3;
  localparam logic [3:0] FN_DEL_FIRST = 4'd4;
  localparam logic [3:0] FN_DEL_LAST = 4'd5;
  localparam logic [3:0] FN_FIND_FIRST = 4'd6;
  localparam logic [3:0] FN_FIND_LAST = 4'd7;
  localparam logic [3:0] FN_POSITION = 4'd8;
  localparam logic [3:0] FN_CLEAR = 4'd9;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_BAD_HANDLE = 2'd3;

  typedef struct packed {
    logic [3:0] func;
    logic signed [31:0] value;
    logic [7:0] handle;
    logic [8:0] position;
  } dll_in_t;

  typedef struct packed {
    logic [7:0] node_handle;
    logic found;
    logic [1:0] status;
  } dll_out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_ALLOC, S_LINK, S_DEL, S_WALK_RD, S_WALK_CHK, S_DONE
  } dll_state_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_CLEAR, OP_ALLOC, OP_LINK, OP_DEL, OP_WALK_START,
    OP_WALK_RD, OP_WALK_STEP, OP_RESPOND
  } dll_op_t;

  typedef struct packed {
    dll_op_t op;
  } dll_cmd_t;

  typedef struct packed {
    logic empty;
    logic live;
    logic pool_full;
    logic walk_end;
    logic walk_hit;
  } dll_stat_t;
endpackage

[src/doubly_linked_list_engine_top.sv]
// Top level of the doubly linked list engine.
// Usage: pulse start with in_item while busy is low; the command is taken at
// that edge and busy stays high until the result is shown.
// Each command gives exactly one result: out_valid is high for one cycle with
// out_item holding node_handle, found and status. The receiver cannot stall.
// Clear and every rejected command go from decode straight to the result.
// Deletes pass through the delete state; insert first, after and before through
// the allocate and link states. Finds and the position lookup walk the list, and
// sorted insert allocates, walks and then links. The walk follows each link
// through a read state and a check state, set by the registered reads of the
// node memories.
// Busy is low again in the cycle that shows the result, so the next command
// may be accepted at the edge that ends that cycle.
// Reset (rst_n low, synchronous) empties the list and the free list and sets
// the fresh pointer to zero; node memories are not cleared and need no pass.
module doubly_linked_list_engine_top #(
  parameter int NODES = dll_pkg::DEF_NODES,
  parameter int VALUE_BITS = dll_pkg::DEF_VALUE_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  dll_pkg::dll_in_t  in_item,
  output logic              out_valid,
  output dll_pkg::dll_out_t out_item
);
  import dll_pkg::*;

  dll_cmd_t cmd;
  dll_stat_t stat;

  dll_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .func(in_item.func),
    .stat(stat), .busy(busy), .cmd(cmd)
  );

  dll_datapath #(.NODES(NODES), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .cmd(cmd), .stat(stat),
    .out_valid(out_valid), .out_item(out_item)
  );
endmodule

[src/dll_ctrl.sv]
// Controller state machine that sequences each list command.
`include "doubly_linked_list_engine_top_defines.svh"
module dll_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [3:0]          func,
  input  dll_pkg::dll_stat_t  stat,
  output logic                busy,
  output dll_pkg::dll_cmd_t   cmd
);
  import dll_pkg::*;

  dll_state_t state_r, state_nxt;
  logic [3:0] func_r, func_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      func_r <= '0;
    end else begin
      state_r <= state_nxt;
      func_r <= func_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    func_nxt = func_r;
    cmd.op = OP_NONE;
    busy = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_LATCH;
          func_nxt = func;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (func_r == FN_CLEAR) begin
          cmd.op = OP_CLEAR;
          state_nxt = S_DONE;
        end else if (func_r == FN_INS_FIRST || func_r == FN_INS_SORTED) begin
          state_nxt = stat.pool_full ? S_DONE : S_ALLOC;
        end else if (func_r == FN_INS_AFTER || func_r == FN_INS_BEFORE) begin
          state_nxt = (!stat.live || stat.pool_full) ? S_DONE : S_ALLOC;
        end else if (func_r == FN_DEL_FIRST || func_r == FN_DEL_LAST) begin
          state_nxt = stat.empty ? S_DONE : S_DEL;
        end else if (func_r == FN_FIND_FIRST || func_r == FN_FIND_LAST
                     || func_r == FN_POSITION) begin
          if (stat.empty) begin
            state_nxt = S_DONE;
          end else begin
            cmd.op = OP_WALK_START;
            state_nxt = S_WALK_RD;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_ALLOC: begin
        cmd.op = OP_ALLOC;
        if (func_r == FN_INS_SORTED) begin
          state_nxt = S_WALK_RD;
        end else begin
          state_nxt = S_LINK;
        end
      end
      S_WALK_RD: begin
        cmd.op = OP_WALK_RD;
        state_nxt = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        if (stat.walk_end || stat.walk_hit) begin
          state_nxt = (func_r == FN_INS_SORTED) ? S_LINK : S_DONE;
        end else begin
          cmd.op = OP_WALK_STEP;
          state_nxt = S_WALK_RD;
        end
      end
      S_LINK: begin
        cmd.op = OP_LINK;
        state_nxt = S_DONE;
      end
      S_DEL: begin
        cmd.op = OP_DEL;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.op = OP_RESPOND;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `DLL_ASSERT_NEXT(a_start_leaves_idle, (state_r == S_IDLE) && start, busy, "start not taken")
  `DLL_ASSERT_NEXT(a_done_returns, state_r == S_DONE, !busy, "block did not return to idle")
  `DLL_ASSERT_IMP(a_idle_quiet, !busy, (cmd.op == OP_NONE) || (cmd.op == OP_LATCH), "op while idle")
endmodule

[src/dll_datapath.sv]
// Datapath with the node memories, list pointers and walk registers.
`include "doubly_linked_list_engine_top_defines.svh"
module dll_datapath #(
  parameter int NODES = dll_pkg::DEF_NODES,
  parameter int VALUE_BITS = dll_pkg::DEF_VALUE_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dll_pkg::dll_in_t    in_item,
  input  dll_pkg::dll_cmd_t   cmd,
  output dll_pkg::dll_stat_t  stat,
  output logic                out_valid,
  output dll_pkg::dll_out_t   out_item
);
  import dll_pkg::*;

  localparam int AW = $clog2(NODES);
  localparam int LW = AW + 1;
  localparam int CW = (LW > 9) ? LW : 9;
  localparam logic [LW-1:0] NIL = LW'(NODES);

  logic [VALUE_BITS-1:0] val_mem [NODES];
  logic [LW-1:0] nxt_mem [NODES];
  logic [LW-1:0] prv_mem [NODES];
  logic [NODES-1:0] in_use_r;

  logic [LW-1:0] head_r, tail_r, free_r, fresh_r;
  logic [3:0] func_r;
  logic [VALUE_BITS-1:0] key_r;
  logic [7:0] hdl_r;
  logic [8:0] pos_r;
  logic [LW-1:0] n_r, p_r, cnt_r;
  logic [VALUE_BITS-1:0] pval_r;
  logic [LW-1:0] pnext_r, pprev_r;
  logic [LW-1:0] res_r;
  logic [1:0] st_r;
  logic rd_ok_r;
  logic [LW-1:0] hdl_ext;
  logic [LW-1:0] cnt_inc;
  logic [AW-1:0] nrd_addr, prd_addr;

  assign hdl_ext = LW'(hdl_r);
  assign cnt_inc = cnt_r + LW'(1);
  assign stat.empty = (head_r == NIL);
  assign stat.live = (hdl_ext < NIL) && in_use_r[hdl_ext[AW-1:0]];
  assign stat.pool_full = (free_r == NIL) && (fresh_r == NIL);
  assign stat.walk_end = (p_r == NIL) || (cnt_r == NIL)
    || ((func_r == FN_POSITION) && (CW'(pos_r) <= CW'(cnt_r)));
  always_comb begin
    stat.walk_hit = 1'b0;
    if (rd_ok_r) begin
      if (func_r == FN_INS_SORTED) begin
        stat.walk_hit = !($signed(pval_r) < $signed(key_r));
      end else if (func_r == FN_FIND_FIRST || func_r == FN_FIND_LAST) begin
        stat.walk_hit = (pval_r == key_r);
      end
    end
  end

  // One read address per link memory: the walk node, the handle node while a node is
  // taken, else free node or head for next, tail or (sorted insert) walk node for prev.
  always_comb begin
    nrd_addr = free_r[AW-1:0];
    prd_addr = tail_r[AW-1:0];
    priority if (cmd.op == OP_WALK_RD) begin
      nrd_addr = p_r[AW-1:0];
      prd_addr = p_r[AW-1:0];
    end else if (cmd.op == OP_ALLOC) begin
      nrd_addr = hdl_ext[AW-1:0];
      prd_addr = hdl_ext[AW-1:0];
    end else if (func_r == FN_DEL_FIRST) begin
      nrd_addr = head_r[AW-1:0];
    end else if (func_r == FN_INS_SORTED) begin
      prd_addr = p_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    pnext_r <= nxt_mem[nrd_addr];
    pprev_r <= prv_mem[prd_addr];
    if (cmd.op == OP_WALK_RD) begin
      pval_r <= val_mem[p_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      head_r <= NIL;
      tail_r <= NIL;
      free_r <= NIL;
      fresh_r <= '0;
      out_valid <= 1'b0;
      rd_ok_r <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (cmd.op)
        OP_LATCH: begin
          func_r <= in_item.func;
          key_r <= VALUE_BITS'(in_item.value);
          hdl_r <= in_item.handle;
          pos_r <= in_item.position;
          res_r <= NIL;
          rd_ok_r <= 1'b0;
          st_r <= ST_OK;
          if (in_item.func == FN_INS_AFTER || in_item.func == FN_INS_BEFORE) begin
            if (!((LW'(in_item.handle) < NIL) && in_use_r[AW'(in_item.handle)])) begin
              st_r <= ST_BAD_HANDLE;
            end else if ((free_r == NIL) && (fresh_r == NIL)) begin
              st_r <= ST_FULL;
            end
          end else if (in_item.func == FN_INS_FIRST || in_item.func == FN_INS_SORTED) begin
            if ((free_r == NIL) && (fresh_r == NIL)) st_r <= ST_FULL;
          end else if (in_item.func >= FN_DEL_FIRST && in_item.func <= FN_POSITION) begin
            if (head_r == NIL) st_r <= ST_EMPTY;
          end
        end
        OP_CLEAR: begin
          in_use_r <= '0;
          head_r <= NIL;
          tail_r <= NIL;
          free_r <= NIL;
          fresh_r <= '0;
        end
        OP_ALLOC: begin
          if (free_r != NIL) begin
            n_r <= free_r;
            free_r <= pnext_r;
            in_use_r[free_r[AW-1:0]] <= 1'b1;
            val_mem[free_r[AW-1:0]] <= key_r;
          end else begin
            n_r <= fresh_r;
            fresh_r <= fresh_r + LW'(1);
            in_use_r[fresh_r[AW-1:0]] <= 1'b1;
            val_mem[fresh_r[AW-1:0]] <= key_r;
          end
          p_r <= head_r;
          cnt_r <= '0;
        end
        OP_LINK: begin
          res_r <= n_r;
          priority if (func_r == FN_INS_FIRST || (func_r == FN_INS_SORTED
                       && (head_r == NIL || p_r == head_r))) begin
            prv_mem[n_r[AW-1:0]] <= NIL;
            nxt_mem[n_r[AW-1:0]] <= head_r;
            if (head_r == NIL) tail_r <= n_r;
            else prv_mem[head_r[AW-1:0]] <= n_r;
            head_r <= n_r;
          end else if (func_r == FN_INS_SORTED && p_r == NIL) begin
            prv_mem[n_r[AW-1:0]] <= tail_r;
            nxt_mem[n_r[AW-1:0]] <= NIL;
            nxt_mem[tail_r[AW-1:0]] <= n_r;
            tail_r <= n_r;
          end else if (func_r == FN_INS_SORTED) begin
            nxt_mem[n_r[AW-1:0]] <= p_r;
            prv_mem[n_r[AW-1:0]] <= pprev_r;
            nxt_mem[pprev_r[AW-1:0]] <= n_r;
            prv_mem[p_r[AW-1:0]] <= n_r;
          end else if (func_r == FN_INS_AFTER) begin
            prv_mem[n_r[AW-1:0]] <= hdl_ext;
            nxt_mem[n_r[AW-1:0]] <= pnext_r;
            if (pnext_r == NIL) tail_r <= n_r;
            else prv_mem[pnext_r[AW-1:0]] <= n_r;
            nxt_mem[hdl_ext[AW-1:0]] <= n_r;
          end else begin
            nxt_mem[n_r[AW-1:0]] <= hdl_ext;
            prv_mem[n_r[AW-1:0]] <= pprev_r;
            if (pprev_r == NIL) head_r <= n_r;
            else nxt_mem[pprev_r[AW-1:0]] <= n_r;
            prv_mem[hdl_ext[AW-1:0]] <= n_r;
          end
        end
        OP_DEL: begin
          if (func_r == FN_DEL_FIRST) begin
            res_r <= head_r;
            in_use_r[head_r[AW-1:0]] <= 1'b0;
            nxt_mem[head_r[AW-1:0]] <= free_r;
            free_r <= head_r;
            head_r <= pnext_r;
            if (pnext_r == NIL) tail_r <= NIL;
            else prv_mem[pnext_r[AW-1:0]] <= NIL;
          end else begin
            res_r <= tail_r;
            in_use_r[tail_r[AW-1:0]] <= 1'b0;
            nxt_mem[tail_r[AW-1:0]] <= free_r;
            free_r <= tail_r;
            tail_r <= pprev_r;
            if (pprev_r == NIL) head_r <= NIL;
            else nxt_mem[pprev_r[AW-1:0]] <= NIL;
          end
        end
        OP_WALK_START: begin
          p_r <= (func_r == FN_FIND_LAST) ? tail_r : head_r;
          cnt_r <= '0;
        end
        OP_WALK_RD: begin
          rd_ok_r <= (p_r != NIL);
        end
        OP_WALK_STEP: begin
          p_r <= (func_r == FN_FIND_LAST) ? pprev_r : pnext_r;
          cnt_r <= cnt_inc;
          rd_ok_r <= 1'b0;
        end
        OP_RESPOND: begin
          out_valid <= 1'b1;
        end
        default: begin
        end
      endcase
      if (cmd.op == OP_WALK_RD) begin
        // Position and find results follow the walk pointer.
        if (func_r == FN_POSITION) res_r <= p_r;
      end
    end
  end

  always_comb begin
    out_item.status = st_r;
    out_item.found = 1'b0;
    out_item.node_handle = '0;
    if ((func_r == FN_FIND_FIRST || func_r == FN_FIND_LAST) && st_r == ST_OK) begin
      out_item.found = stat.walk_hit;
      out_item.node_handle = stat.walk_hit ? 8'(p_r) : 8'd0;
    end else if (res_r != NIL && st_r == ST_OK && func_r != FN_CLEAR && func_r <= FN_POSITION) begin
      out_item.found = 1'b1;
      out_item.node_handle = 8'(res_r);
    end
  end

  `DLL_ASSERT_IMP(a_head_tail_null, head_r == NIL, tail_r == NIL, "head null but tail not")
  `DLL_ASSERT_IMP(a_fresh_range, 1'b1, fresh_r <= NIL, "fresh pointer past pool")
  `DLL_ASSERT_NEXT(a_alloc_marks, cmd.op == OP_ALLOC, in_use_r[n_r[AW-1:0]], "allocated node not in use")
endmodule

[test/tb_doubly_linked_list_engine_top.sv]
// Self-checking testbench for the doubly linked list engine: random and directed commands.
`timescale 1ns / 1ps
module tb_doubly_linked_list_engine_top;
  import dll_pkg::*;

  localparam int NN = DEF_NODES;
  localparam int NIL = NN;
  localparam longint LIMIT = 10000000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  dll_in_t in_item;
  logic out_valid;
  dll_out_t out_item;

  doubly_linked_list_engine_top i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  dll_in_t pending_cmds[$];
  dll_out_t expected_answers[$];
  int errors;
  bit quiet;
  longint cycles;

  logic signed [31:0] m_val[NN];
  int m_next[NN];
  int m_prev[NN];
  bit m_used[NN];
  int m_head, m_tail, m_free, m_fresh;

  function automatic void list_reset();
    for (int i = 0; i < NN; i++) m_used[i] = 0;
    m_head = NIL;
    m_tail = NIL;
    m_free = NIL;
    m_fresh = 0;
  endfunction

  function automatic int alloc_node(logic signed [31:0] v);
    int n;
    if (m_free < NIL) begin
      n = m_free;
      m_free = m_next[n];
    end else if (m_fresh < NIL) begin
      n = m_fresh;
      m_fresh++;
    end else begin
      return NIL;
    end
    m_used[n] = 1;
    m_val[n] = v;
    m_next[n] = NIL;
    m_prev[n] = NIL;
    return n;
  endfunction

  function automatic void put_first(int n);
    m_prev[n] = NIL;
    m_next[n] = m_head;
    if (m_head >= NIL) m_tail = n;
    else m_prev[m_head] = n;
    m_head = n;
  endfunction

  function automatic void put_after(int at, int n);
    int nx;
    nx = m_next[at];
    m_prev[n] = at;
    m_next[n] = nx;
    if (nx >= NIL) m_tail = n;
    else m_prev[nx] = n;
    m_next[at] = n;
  endfunction

  function automatic void put_before(int at, int n);
    int pv;
    pv = m_prev[at];
    m_next[n] = at;
    m_prev[n] = pv;
    if (pv >= NIL) m_head = n;
    else m_next[pv] = n;
    m_prev[at] = n;
  endfunction

  function automatic dll_out_t list_answer(dll_in_t c);
    dll_out_t r;
    int res, n, p;
    logic [1:0] st;
    res = NIL;
    st = ST_OK;
    case (c.func)
      FN_INS_FIRST: begin
        n = alloc_node(c.value);
        if (n >= NIL) st = ST_FULL;
        else begin
          put_first(n);
          res = n;
        end
      end
      FN_INS_AFTER, FN_INS_BEFORE: begin
        if (!m_used[c.handle]) st = ST_BAD_HANDLE;
        else begin
          n = alloc_node(c.value);
          if (n >= NIL) st = ST_FULL;
          else begin
            if (c.func == FN_INS_AFTER) put_after(c.handle, n);
            else put_before(c.handle, n);
            res = n;
          end
        end
      end
      FN_INS_SORTED: begin
        n = alloc_node(c.value);
        if (n >= NIL) st = ST_FULL;
        else begin
          p = m_head;
          while (p < NIL && m_val[p] < c.value) p = m_next[p];
          if (m_head >= NIL || p == m_head) put_first(n);
          else if (p >= NIL) put_after(m_tail, n);
          else put_before(p, n);
          res = n;
        end
      end
      FN_DEL_FIRST, FN_DEL_LAST: begin
        if (m_head >= NIL) st = ST_EMPTY;
        else begin
          if (c.func == FN_DEL_FIRST) begin
            n = m_head;
            m_head = m_next[n];
            if (m_head >= NIL) m_tail = NIL;
            else m_prev[m_head] = NIL;
          end else begin
            n = m_tail;
            m_tail = m_prev[n];
            if (m_tail >= NIL) m_head = NIL;
            else m_next[m_tail] = NIL;
          end
          m_used[n] = 0;
          m_next[n] = m_free;
          m_free = n;
          res = n;
        end
      end
      FN_FIND_FIRST, FN_FIND_LAST: begin
        if (m_head >= NIL) st = ST_EMPTY;
        else begin
          p = (c.func == FN_FIND_FIRST) ? m_head : m_tail;
          while (p < NIL) begin
            if (m_val[p] == c.value) begin
              res = p;
              break;
            end
            p = (c.func == FN_FIND_FIRST) ? m_next[p] : m_prev[p];
          end
        end
      end
      FN_POSITION: begin
        if (m_head >= NIL) st = ST_EMPTY;
        else begin
          p = m_head;
          for (int i = 0; i < c.position && p < NIL; i++) p = m_next[p];
          res = p;
        end
      end
      FN_CLEAR: list_reset();
      default: ;
    endcase
    r.node_handle = (res < NIL) ? res[7:0] : 8'd0;
    r.found = (res < NIL);
    r.status = st;
    return r;
  endfunction

  // Values come from a small set most of the time so that finds and sorted inserts hit.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return $signed($urandom_range(0, 15)) - 8;
    endcase
  endfunction

  function automatic dll_in_t make_cmd(logic [3:0] f, logic signed [31:0] v, int h, int p);
    dll_in_t c;
    c.func = f;
    c.value = v;
    c.handle = 8'(h);
    c.position = 9'(p);
    return c;
  endfunction

  function automatic dll_in_t random_cmd(int fill_bias);
    dll_in_t c;
    int r;
    c.value = pick_value();
    c.handle = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 40));
    c.position = ($urandom_range(0, 7) == 0) ? 9'($urandom()) : 9'($urandom_range(0, 45));
    r = $urandom_range(0, 99);
    if (r < fill_bias) c.func = 4'($urandom_range(0, 3));
    else if (r < 98) c.func = 4'($urandom_range(4, 8));
    else if (r < 99) c.func = FN_CLEAR;
    else c.func = 4'($urandom_range(10, 15));
    return c;
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 0;
      in_item <= '0;
      quiet <= 0;
    end else begin
      if (cycles == 3000) quiet <= 1;
      if (cycles == 9000) quiet <= 0;
      if (start && !busy) begin
        expected_answers.push_back(list_answer(in_item));
      end
      if (!(start && busy)) begin
        if (pending_cmds.size() > 0 && (quiet || $urandom_range(0, 99) >= 32)) begin
          start <= 1;
          in_item <= pending_cmds.pop_front();
        end else begin
          start <= 0;
          in_item <= make_cmd(4'($urandom()), $urandom(), $urandom(), $urandom());
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_item);
        errors++;
      end else begin
        dll_out_t e;
        e = expected_answers.pop_front();
        if (e.node_handle !== out_item.node_handle || e.found !== out_item.found
            || e.status !== out_item.status) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, out_item);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    start = 0;
    in_item = '0;
    list_reset();
    pending_cmds.push_back(make_cmd(FN_DEL_FIRST, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FN_DEL_LAST, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FN_FIND_FIRST, 1, 0, 0));
    pending_cmds.push_back(make_cmd(FN_POSITION, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FN_INS_AFTER, 5, 0, 0));
    pending_cmds.push_back(make_cmd(FN_INS_SORTED, 3, 0, 0));
    pending_cmds.push_back(make_cmd(FN_INS_FIRST, 32'sh7fffffff, 0, 0));
    pending_cmds.push_back(make_cmd(FN_INS_AFTER, 32'sh80000000, 0, 0));
    pending_cmds.push_back(make_cmd(FN_INS_BEFORE, -1, 1, 0));
    pending_cmds.push_back(make_cmd(FN_INS_BEFORE, 2, 255, 0));
    pending_cmds.push_back(make_cmd(FN_INS_SORTED, 32'sh80000000, 0, 0));
    pending_cmds.push_back(make_cmd(FN_INS_SORTED, 32'sh7fffffff, 0, 0));
    pending_cmds.push_back(make_cmd(FN_INS_SORTED, 3, 0, 0));
    pending_cmds.push_back(make_cmd(FN_FIND_FIRST, 3, 0, 0));
    pending_cmds.push_back(make_cmd(FN_FIND_LAST, 32'sh7fffffff, 0, 0));
    pending_cmds.push_back(make_cmd(FN_FIND_LAST, 99, 0, 0));
    pending_cmds.push_back(make_cmd(FN_POSITION, 0, 0, 2));
    pending_cmds.push_back(make_cmd(FN_POSITION, 0, 0, 511));
    pending_cmds.push_back(make_cmd(FN_DEL_LAST, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FN_DEL_FIRST, 0, 0, 0));
    pending_cmds.push_back(make_cmd(4'd15, -1, 255, 511));
    pending_cmds.push_back(make_cmd(FN_CLEAR, 0, 0, 0));
    for (int i = 0; i < 258; i++)
      pending_cmds.push_back(make_cmd(FN_INS_FIRST, 32'($signed(i[3:0])), 0, 0));
    pending_cmds.push_back(make_cmd(FN_INS_AFTER, 1, 255, 0));
    pending_cmds.push_back(make_cmd(FN_INS_SORTED, 1, 0, 0));
    pending_cmds.push_back(make_cmd(FN_POSITION, 0, 0, 255));
    pending_cmds.push_back(make_cmd(FN_POSITION, 0, 0, 256));
    pending_cmds.push_back(make_cmd(FN_FIND_FIRST, -1, 0, 0));
    pending_cmds.push_back(make_cmd(FN_CLEAR, 0, 0, 0));
    for (int i = 0; i < 1250; i++)
      pending_cmds.push_back(random_cmd((i % 400) < 200 ? 70 : 40));
    pending_cmds.push_back(make_cmd(FN_CLEAR, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FN_DEL_LAST, 0, 0, 0));
    wait (pending_cmds.size() == 0 && !start);
    wait (expected_answers.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_answers.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

[sim.f]
+incdir+src
src/dll_pkg.sv
src/dll_ctrl.sv
src/dll_datapath.sv
src/doubly_linked_list_engine_top.sv
test/tb_doubly_linked_list_engine_top.sv
